@@ sv/wsd_pkg.sv @@
// shared types and constants for the websocket frame deframer
package wsd_pkg;

  localparam logic [31:0] BufSizeReset = 32'd1024;
  localparam logic [3:0]  OpClose      = 4'h8;
  localparam logic [6:0]  Len16Code    = 7'd126;
  localparam logic [6:0]  Len64Code    = 7'd127;
  localparam logic [3:0]  Ext16Bytes   = 4'd2;
  localparam logic [3:0]  Ext64Bytes   = 4'd8;
  localparam logic [3:0]  KeyBytes     = 4'd4;

  localparam logic [1:0]  StatusOk     = 2'd0;
  localparam logic [1:0]  StatusClose  = 2'd1;
  localparam logic [1:0]  StatusTooBig = 2'd2;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_EMPTY = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_e;

  // one entry of the queue between parser and output stage
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
    logic [3:0]  opcode;
    logic [31:0] flen;
  } cmd_t;

endpackage

@@ sv/wsd_front.sv @@
// header parser: tracks frame state and turns payload bytes and frame outcomes into queue commands
module wsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               fire_i,
  input  logic [7:0]         rx_byte_i,
  output logic               push_o,
  output wsd_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  left_q, left_d;
  logic [31:0] key_q, key_d;
  logic [31:0] pos_q, pos_d;
  logic        halted_q, halted_d;
  logic [31:0] bufsize_q;

  logic        len_done, hdr_done, use_mask;
  logic [63:0] hdr_len;
  logic [7:0]  key_byte;

  always_comb begin
    case (pos_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    len_d    = len_q;
    left_d   = left_q;
    key_d    = key_q;
    pos_d    = pos_q;
    halted_d = halted_q;
    len_done = 1'b0;
    hdr_done = 1'b0;
    use_mask = mask_q;
    hdr_len  = len_q;
    push_o   = 1'b0;
    cmd_o.kind   = wsd_pkg::CMD_DATA;
    cmd_o.data   = rx_byte_i;
    cmd_o.key    = key_byte;
    cmd_o.last   = 1'b0;
    cmd_o.opcode = opcode_q;
    cmd_o.flen   = '0;

    if (fire_i && !halted_q) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d   = rx_byte_i[7];
          use_mask = rx_byte_i[7];
          if (rx_byte_i[6:0] == wsd_pkg::Len16Code ||
              rx_byte_i[6:0] == wsd_pkg::Len64Code) begin
            len_d   = '0;
            left_d  = (rx_byte_i[6:0] == wsd_pkg::Len16Code) ?
                      wsd_pkg::Ext16Bytes : wsd_pkg::Ext64Bytes;
            phase_d = PH_EXT;
          end else begin
            len_d    = {57'd0, rx_byte_i[6:0]};
            hdr_len  = len_d;
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          len_d   = {len_q[55:0], rx_byte_i};
          hdr_len = len_d;
          left_d  = left_q - 4'd1;
          if (left_d == 4'd0) begin
            len_done = 1'b1;
          end
        end
        PH_MASK: begin
          key_d  = {key_q[23:0], rx_byte_i};
          left_d = left_q - 4'd1;
          if (left_d == 4'd0) begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          pos_d      = pos_q + 32'd1;
          push_o     = 1'b1;
          cmd_o.last = (pos_d == len_q[31:0]);
          if (cmd_o.last) begin
            cmd_o.flen = len_q[31:0];
            phase_d    = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      if (len_done) begin
        key_d = '0;
        if (use_mask) begin
          left_d  = wsd_pkg::KeyBytes;
          phase_d = PH_MASK;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        if (hdr_len[63:32] != 32'd0 || hdr_len[31:0] >= bufsize_q) begin
          push_o     = 1'b1;
          cmd_o.kind = wsd_pkg::CMD_ERROR;
          cmd_o.last = 1'b1;
          cmd_o.flen = (hdr_len[63:32] != 32'd0) ? 32'hFFFF_FFFF : hdr_len[31:0];
          halted_d   = 1'b1;
          phase_d    = PH_HDR0;
        end else if (hdr_len[31:0] == 32'd0) begin
          push_o     = 1'b1;
          cmd_o.kind = wsd_pkg::CMD_EMPTY;
          cmd_o.last = 1'b1;
          phase_d    = PH_HDR0;
        end else begin
          pos_d   = '0;
          phase_d = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      opcode_q  <= '0;
      mask_q    <= 1'b0;
      len_q     <= '0;
      left_q    <= '0;
      key_q     <= '0;
      pos_q     <= '0;
      halted_q  <= 1'b0;
      bufsize_q <= wsd_pkg::BufSizeReset;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      left_q   <= left_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
      halted_q <= halted_d;
      if (cfg_we_i) begin
        bufsize_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ sv/wsd_queue.sv @@
// two-entry command queue between parser and output stage
module wsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output wsd_pkg::cmd_t cmd_o
);

  wsd_pkg::cmd_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ sv/wsd_back.sv @@
// output stage: unmasks payload, forms status and holds the result register
module wsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  wsd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    payload_byte_o,
  output logic          has_data_o,
  output logic          last_o,
  output logic [3:0]    frame_opcode_o,
  output logic [1:0]    status_o,
  output logic [31:0]   frame_length_o
);

  logic        valid_q;
  logic [7:0]  byte_q;
  logic        has_q, last_q;
  logic [3:0]  op_q;
  logic [1:0]  status_q, status_d;
  logic [31:0] flen_q;
  logic        is_data;

  assign pop_o   = avail_i && (!valid_q || out_ready_i);
  assign is_data = (cmd_i.kind == wsd_pkg::CMD_DATA);

  always_comb begin
    if (cmd_i.kind == wsd_pkg::CMD_ERROR) begin
      status_d = wsd_pkg::StatusTooBig;
    end else if (cmd_i.opcode == wsd_pkg::OpClose) begin
      status_d = wsd_pkg::StatusClose;
    end else begin
      status_d = wsd_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= is_data ? (cmd_i.data ^ cmd_i.key) : 8'd0;
      has_q    <= is_data;
      last_q   <= cmd_i.last;
      op_q     <= cmd_i.opcode;
      status_q <= status_d;
      flen_q   <= cmd_i.flen;
    end
  end

  assign out_valid_o    = valid_q;
  assign payload_byte_o = byte_q;
  assign has_data_o     = has_q;
  assign last_o         = last_q;
  assign frame_opcode_o = op_q;
  assign status_o       = status_q;
  assign frame_length_o = flen_q;

endmodule

@@ sv/websocket_frame_deframer.sv @@
// websocket frame deframer top: parser, command queue and output stage
// one byte accepted per cycle while the queue is not full; after its byte is taken,
// a result passes through the queue and then the output register
// sustained rate one byte per cycle while the output accepts results
// reset clears parser state, queue and output valid; buffer size resets to 1024
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic        has_data_o,
  output logic        last_o,
  output logic [3:0]  frame_opcode_o,
  output logic [1:0]  status_o,
  output logic [31:0] frame_length_o
);

  wsd_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_full, q_empty, fire;

  assign in_ready_o = !q_full;
  assign fire       = in_valid_i && in_ready_o;

  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (!q_empty),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .has_data_o     (has_data_o),
    .last_o         (last_o),
    .frame_opcode_o (frame_opcode_o),
    .status_o       (status_o),
    .frame_length_o (frame_length_o)
  );

endmodule

@@ test/tb.sv @@
// testbench for the websocket frame deframer: byte stream in, frame results checked out
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;

  typedef enum logic [2:0] {ST_OPCODE, ST_LEN7, ST_EXTLEN, ST_KEY, ST_PAYLOAD} parse_state_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {ENC_LEN7, ENC_LEN16, ENC_LEN64} len_enc_e;

  typedef struct packed {
    logic [7:0]  payload;
    logic        has_data;
    logic        last;
    logic [3:0]  opcode;
    logic [1:0]  status;
    logic [31:0] flen;
  } frame_res_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    frame_res_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  payload_byte_o;
  logic        has_data_o;
  logic        last_o;
  logic [3:0]  frame_opcode_o;
  logic [1:0]  status_o;
  logic [31:0] frame_length_o;

  websocket_frame_deframer DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser mirror
  logic [31:0]  buf_limit = wsd_pkg::BufSizeReset;
  parse_state_e pst = ST_OPCODE;
  logic [3:0]   cur_op = '0;
  logic         masked = 1'b0;
  logic [63:0]  frame_len = '0;
  logic [3:0]   hdr_left = '0;
  logic [31:0]  mask_key = '0;
  logic [31:0]  pay_pos = '0;
  logic         halted = 1'b0;

  frame_res_t  pending_res[$];
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  function automatic logic [1:0] frame_status();
    return (cur_op == wsd_pkg::OpClose) ? wsd_pkg::StatusClose : wsd_pkg::StatusOk;
  endfunction

  // whole header seen: reject, close out an empty frame, or start the payload
  function automatic bit header_known(output frame_res_t r);
    r = '0;
    r.opcode = cur_op;
    r.last = 1'b1;
    if (frame_len >= {32'd0, buf_limit}) begin
      r.status = wsd_pkg::StatusTooBig;
      r.flen = (frame_len[63:32] != '0) ? 32'hFFFF_FFFF : frame_len[31:0];
      halted = 1'b1;
      pst = ST_OPCODE;
      return 1'b1;
    end
    if (frame_len == '0) begin
      r.status = frame_status();
      pst = ST_OPCODE;
      return 1'b1;
    end
    pay_pos = '0;
    pst = ST_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit length_known(output frame_res_t r);
    r = '0;
    mask_key = '0;
    if (masked) begin
      hdr_left = wsd_pkg::KeyBytes;
      pst = ST_KEY;
      return 1'b0;
    end
    return header_known(r);
  endfunction

  function automatic bit parse_rx_byte(input logic [7:0] b, output frame_res_t r);
    logic [7:0] kb;
    r = '0;
    if (halted) return 1'b0;
    case (pst)
      ST_OPCODE: begin
        cur_op = b[3:0];
        pst = ST_LEN7;
        return 1'b0;
      end
      ST_LEN7: begin
        masked = b[7];
        if (b[6:0] == wsd_pkg::Len16Code || b[6:0] == wsd_pkg::Len64Code) begin
          frame_len = '0;
          hdr_left = (b[6:0] == wsd_pkg::Len16Code) ? wsd_pkg::Ext16Bytes :
                     wsd_pkg::Ext64Bytes;
          pst = ST_EXTLEN;
          return 1'b0;
        end
        frame_len = {57'd0, b[6:0]};
        return length_known(r);
      end
      ST_EXTLEN: begin
        // extended length arrives big-endian
        frame_len = {frame_len[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != '0) return 1'b0;
        return length_known(r);
      end
      ST_KEY: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != '0) return 1'b0;
        return header_known(r);
      end
      ST_PAYLOAD: begin
        // first key byte received covers positions 0, 4, 8 ...
        kb = mask_key[8 * (3 - pay_pos[1:0]) +: 8];
        pay_pos = pay_pos + 32'd1;
        r.payload = b ^ kb;
        r.has_data = 1'b1;
        r.opcode = cur_op;
        r.status = frame_status();
        if ({32'd0, pay_pos} == frame_len) begin
          r.last = 1'b1;
          r.flen = frame_len[31:0];
          pst = ST_OPCODE;
        end
        return 1'b1;
      end
      default: begin
        pst = ST_OPCODE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input frame_res_t want = '0);
    frame_res_t r;
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 81 : (idle_mode == IDLE_BOTH) ? 33 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (parse_rx_byte(b, r) || typed) pending_res.push_back(typed ? want : r);
  endtask

  task automatic send_frame(input logic [3:0] op, input bit mask, input logic [63:0] len,
                            input len_enc_e enc);
    push_byte({4'($urandom), op});
    if (enc == ENC_LEN7 && len >= 64'(wsd_pkg::Len16Code)) enc = ENC_LEN16;
    if (enc == ENC_LEN16 && len > 64'hFFFF) enc = ENC_LEN64;
    case (enc)
      ENC_LEN7: push_byte({mask, len[6:0]});
      ENC_LEN16: begin
        push_byte({mask, wsd_pkg::Len16Code});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({mask, wsd_pkg::Len64Code});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
    if (mask) repeat (wsd_pkg::KeyBytes) push_byte(8'($urandom));
    // a rejected frame stops the parser, so its body is never sent
    if (len < {32'd0, buf_limit})
      for (longint unsigned i = 0; i < len; i++) push_byte(8'($urandom));
  endtask

  task automatic random_frame();
    logic [63:0] len;
    int unsigned pick;
    len_enc_e    enc;
    logic [3:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 80) len = 64'($urandom_range(0, 10));
    else if (pick < 95) len = 64'($urandom_range(11, 40));
    else if (pick < 99) len = 64'($urandom_range(41, 125));
    else len = 64'($urandom_range(126, 260));
    if (len >= {32'd0, buf_limit}) len = 64'($urandom_range(0, buf_limit - 1));
    pick = $urandom_range(0, 99);
    enc = (pick < 60) ? ENC_LEN7 : (pick < 85) ? ENC_LEN16 : ENC_LEN64;
    op = ($urandom_range(0, 3) == 0) ? wsd_pkg::OpClose : 4'($urandom);
    send_frame(op, 1'($urandom), len, enc);
  endtask

  task automatic frames_until(input int unsigned target);
    while (items_sent < target) random_frame();
  endtask

  task automatic set_buf_limit(input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    buf_limit = v;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_side
    frame_res_t want;
    int unsigned stall_pct;
    if (out_valid_o && out_ready_i) begin
      if (pending_res.size() == 0) begin
        // no transaction left that could have caused it
        $error("unexpected result: payload_byte 0x%0h last %0b status %0d",
               payload_byte_o, last_o, status_o);
        mismatches++;
      end else begin
        want = pending_res.pop_front();
        check_field("payload_byte", 32'(want.payload), 32'(payload_byte_o));
        check_field("has_data", 32'(want.has_data), 32'(has_data_o));
        check_field("last", 32'(want.last), 32'(last_o));
        check_field("frame_opcode", 32'(want.opcode), 32'(frame_opcode_o));
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("frame_length", want.flen, frame_length_o);
      end
    end
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HoldCycles;
    end
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 81 : (idle_mode == IDLE_BOTH) ? 33 : 0;
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows [27];
    logic [63:0] big;
    rows = '{
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 4'hF, wsd_pkg::StatusOk, 32'd0}},
      '{8'h88, 1'b0, '0},
      '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, wsd_pkg::OpClose, wsd_pkg::StatusClose, 32'd0}},
      // masked close frame with a 16-bit length, key wraps on the fifth byte
      '{8'h88, 1'b0, '0},
      '{8'hFE, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h05, 1'b0, '0},
      '{8'hA1, 1'b0, '0},
      '{8'hB2, 1'b0, '0},
      '{8'hC3, 1'b0, '0},
      '{8'hD4, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h5A, 1'b0, '0},
      '{8'hA5, 1'b0, '0},
      '{8'h0F, 1'b0, '0},
      // empty frame spelled with a 64-bit length
      '{8'h09, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 4'h9, wsd_pkg::StatusOk, 32'd0}}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) push_byte(rows[i].rx, rows[i].typed, rows[i].want);

    set_buf_limit(32'hFFFF_FFFF);
    idle_mode = IDLE_SENDER;
    frames_until(170);

    // smallest limit: only empty frames get through
    set_buf_limit(32'd1);
    idle_mode = IDLE_RECEIVER;
    while (items_sent < 230)
      send_frame(4'($urandom), 1'($urandom), '0, len_enc_e'($urandom_range(0, 2)));

    set_buf_limit(32'($urandom_range(64, 400)));
    idle_mode = IDLE_BOTH;
    frames_until(370);

    // long output hold-off so the block backs up into its input
    set_buf_limit(32'hFFFF_FFFF);
    idle_mode = IDLE_NONE;
    hold_requests++;
    frames_until(510);

    set_buf_limit(32'($urandom_range(2, 40)));
    while (items_sent < 620) begin
      idle_mode = idle_mode_e'($urandom_range(0, 3));
      random_frame();
    end
    send_frame(4'($urandom), 1'($urandom), 64'(buf_limit - 32'd1),
               len_enc_e'($urandom_range(0, 2)));

    // one rejected frame, after which the parser stays stopped
    case ($urandom_range(0, 2))
      0: big = {32'd0, buf_limit};
      1: big = {32'd0, 32'hFFFF_FFFF};
      default: big = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
    endcase
    send_frame(($urandom_range(0, 1) == 1) ? wsd_pkg::OpClose : 4'($urandom),
               1'($urandom), big, len_enc_e'($urandom_range(0, 2)));
    repeat (8) push_byte(8'($urandom));

    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
